// File: rtl/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// hrhp_pkg
// Shared types, prefix strings and helpers for the HTTP response header parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_LENGTH = 2'd2,
    KIND_DATE   = 2'd3
  } kind_e;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_1    = 8'h31;
  localparam logic [7:0] CHAR_9    = 8'h39;

  localparam logic [9:0]  STATUS_OK  = 10'd200;
  localparam logic [1:0]  VER_0      = 2'd0;
  localparam logic [1:0]  VER_1      = 2'd1;
  localparam logic [1:0]  VER_UNKNOWN = 2'd2;
  localparam logic [4:0]  POS_MAX    = 5'd31;
  localparam logic [4:0]  POS_VERSION = 5'd7;
  localparam logic [4:0]  POS_STATUS_DIGITS = 5'd9;
  localparam logic [1:0]  STATUS_DIGITS = 2'd3;

  localparam int NumPfx = 3;
  localparam int PfxStatusLen = 7;
  localparam int PfxLengthLen = 16;
  localparam int PfxDateLen   = 15;

  localparam logic [PfxStatusLen*8-1:0] PFX_STATUS = "HTTP/1.";
  localparam logic [PfxLengthLen*8-1:0] PFX_LENGTH = "Content-Length: ";
  localparam logic [PfxDateLen*8-1:0]   PFX_DATE   = "Last-Modified: ";

  function automatic logic [4:0] pfx_len(input logic [1:0] k);
    logic [4:0] len;
    case (k)
      2'd0:    len = 5'(PfxStatusLen);
      2'd1:    len = 5'(PfxLengthLen);
      default: len = 5'(PfxDateLen);
    endcase
    return len;
  endfunction

  // Character at position p of prefix k; caller keeps p below the prefix length.
  function automatic logic [7:0] pfx_byte(input logic [1:0] k, input logic [4:0] p);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      2'd0: begin
        if (p < 5'(PfxStatusLen)) c = PFX_STATUS[8*(PfxStatusLen-1-int'(p)) +: 8];
      end
      2'd1: begin
        if (p < 5'(PfxLengthLen)) c = PFX_LENGTH[8*(PfxLengthLen-1-int'(p)) +: 8];
      end
      default: begin
        if (p < 5'(PfxDateLen)) c = PFX_DATE[8*(PfxDateLen-1-int'(p)) +: 8];
      end
    endcase
    return c;
  endfunction

endpackage

// File: rtl/hrhp_if.sv
// ----------------------------------------------------------------------------
// hrhp_if
// Valid/ready channels of the HTTP response header parser.
// ----------------------------------------------------------------------------
interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_response;

  modport source (output valid, output data_byte, output new_response, input ready);
  modport sink   (input valid, input data_byte, input new_response, output ready);
endinterface

interface hrhp_out_if;
  logic        valid;
  logic        ready;
  logic        header_done;
  logic        bad_status;
  logic [9:0]  status_code;
  logic [1:0]  minor_version;
  logic [31:0] body_length;
  logic [7:0]  date_char;
  logic        date_char_valid;

  modport source (output valid, output header_done, output bad_status, output status_code,
                  output minor_version, output body_length, output date_char,
                  output date_char_valid, input ready);
  modport sink   (input valid, input header_done, input bad_status, input status_code,
                  input minor_version, input body_length, input date_char,
                  input date_char_valid, output ready);
endinterface

// File: rtl/http_response_header_parser.sv
// ----------------------------------------------------------------------------
// http_response_header_parser
// Byte-wide HTTP response header parser with a registered result per byte.
// ----------------------------------------------------------------------------
// Takes one byte per cycle and returns one result beat per byte, in the cycle
// after the byte is taken; a new byte is accepted every cycle as long as the
// result register is empty or being drained. The parse state (line position,
// prefix matchers, status/length accumulators, Last-Modified counter) updates
// in the same cycle as the byte, so the throughput is set by that single
// update path, which holds multiply-by-ten steps for the status and length values.
// new_response on a byte clears all parse state before that byte is used.
// Once the blank line or a bad status is seen, bytes are ignored until the
// next new_response.
module http_response_header_parser #(
  parameter int unsigned DATE_MAX = 63
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hrhp_in_if.sink    in_i,
  hrhp_out_if.source out_o
);

  localparam int DateW = $clog2(DATE_MAX + 1);
  localparam logic [DateW-1:0] DateMax = DateW'(DATE_MAX);

  typedef struct packed {
    logic [4:0]           pos;
    logic [2:0]           cand;
    hrhp_pkg::kind_e      kind;
    logic [9:0]           status;
    logic [1:0]           sdig;
    logic [1:0]           ver;
    logic [31:0]          len;
    logic                 digits;
    logic [DateW-1:0]     dcnt;
  } parse_t;

  typedef struct packed {
    parse_t st;
    logic   emit;
  } step_t;

  localparam parse_t ParseReset = '{
    pos:    '0,
    cand:   3'b111,
    kind:   hrhp_pkg::KIND_NONE,
    status: '0,
    sdig:   '0,
    ver:    hrhp_pkg::VER_UNKNOWN,
    len:    '0,
    digits: 1'b0,
    dcnt:   '0
  };

  function automatic step_t take_char(input parse_t s, input logic [7:0] b,
                                      input logic may_emit);
    step_t       r;
    logic        is_digit;
    logic [3:0]  d;
    logic [13:0] sv;
    logic [35:0] lv;
    logic [1:0]  k2;
    r.st     = s;
    r.emit   = 1'b0;
    is_digit = (b >= hrhp_pkg::CHAR_0) && (b <= hrhp_pkg::CHAR_9);
    d        = 4'(b - hrhp_pkg::CHAR_0);
    case (s.kind)
      hrhp_pkg::KIND_STATUS: begin
        if (s.pos == hrhp_pkg::POS_VERSION) begin
          r.st.ver = (b == hrhp_pkg::CHAR_0) ? hrhp_pkg::VER_0 :
                     (b == hrhp_pkg::CHAR_1) ? hrhp_pkg::VER_1 : hrhp_pkg::VER_UNKNOWN;
        end else if (s.pos >= hrhp_pkg::POS_STATUS_DIGITS && s.digits) begin
          if (is_digit && s.sdig < hrhp_pkg::STATUS_DIGITS) begin
            sv         = {1'b0, s.status, 3'b000} + {3'b000, s.status, 1'b0} + 14'(d);
            r.st.status = sv[9:0];
            r.st.sdig  = s.sdig + 2'd1;
          end else begin
            r.st.digits = 1'b0;
          end
        end
      end
      hrhp_pkg::KIND_LENGTH: begin
        if (s.pos >= 5'(hrhp_pkg::PfxLengthLen) && s.digits) begin
          if (is_digit) begin
            lv = {1'b0, s.len, 3'b000} + {3'b000, s.len, 1'b0} + 36'(d);
            r.st.len = (lv[35:32] != 4'd0) ? 32'hFFFF_FFFF : lv[31:0];
          end else begin
            r.st.digits = 1'b0;
          end
        end
      end
      hrhp_pkg::KIND_DATE: begin
        if (s.pos >= 5'(hrhp_pkg::PfxDateLen) && s.dcnt < DateMax) begin
          r.emit  = may_emit;
          r.st.dcnt = s.dcnt + DateW'(1);
        end
      end
      default: ;
    endcase

    for (int k = 0; k < hrhp_pkg::NumPfx; k++) begin
      k2 = 2'(k);
      if (s.cand[k] && s.pos < hrhp_pkg::pfx_len(k2)) begin
        if (b != hrhp_pkg::pfx_byte(k2, s.pos)) begin
          r.st.cand[k] = 1'b0;
        end else if (s.pos == hrhp_pkg::pfx_len(k2) - 5'd1) begin
          r.st.kind   = hrhp_pkg::kind_e'(k2 + 2'd1);
          r.st.digits = 1'b1;
          if (k == 0) begin
            r.st.status = '0;
            r.st.sdig   = '0;
          end else if (k == 1) begin
            r.st.len = '0;
          end else begin
            r.st.dcnt = '0;
          end
        end
      end
    end

    if (s.pos < hrhp_pkg::POS_MAX) r.st.pos = s.pos + 5'd1;
    return r;
  endfunction

  parse_t st_q, st_d;
  logic   cr_q, cr_d;
  logic   done_q, done_d;
  logic   err_q, err_d;
  logic   emit;
  logic   accept;
  logic   out_valid_q;

  step_t  cr_step, byte_step;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    parse_t s;
    s      = st_q;
    cr_d   = cr_q;
    done_d = done_q;
    err_d  = err_q;
    if (in_i.new_response) begin
      s      = ParseReset;
      cr_d   = 1'b0;
      done_d = 1'b0;
      err_d  = 1'b0;
    end
    st_d = s;
    emit = 1'b0;
    // a pending CR that is not followed by LF counts as a plain character
    cr_step   = take_char(s, hrhp_pkg::CHAR_CR, 1'b0);
    byte_step = take_char(cr_d ? cr_step.st : s, in_i.data_byte, 1'b1);
    if (!done_d && !err_d) begin
      if (cr_d) begin
        cr_d = 1'b0;
        if (in_i.data_byte == hrhp_pkg::CHAR_LF) begin
          if (s.kind == hrhp_pkg::KIND_STATUS && s.status != hrhp_pkg::STATUS_OK) begin
            err_d = 1'b1;
          end
          if (s.pos == '0) done_d = 1'b1;
          st_d        = s;
          st_d.pos    = '0;
          st_d.cand   = 3'b111;
          st_d.kind   = hrhp_pkg::KIND_NONE;
          st_d.digits = 1'b0;
          st_d.dcnt   = '0;
        end else if (in_i.data_byte == hrhp_pkg::CHAR_CR) begin
          st_d = cr_step.st;
          cr_d = 1'b1;
        end else begin
          st_d = byte_step.st;
          emit = byte_step.emit;
        end
      end else if (in_i.data_byte == hrhp_pkg::CHAR_CR) begin
        cr_d = 1'b1;
      end else begin
        st_d = byte_step.st;
        emit = byte_step.emit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ParseReset;
      cr_q        <= 1'b0;
      done_q      <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        st_q   <= st_d;
        cr_q   <= cr_d;
        done_q <= done_d;
        err_q  <= err_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_o.header_done     <= done_d;
      out_o.bad_status      <= err_d;
      out_o.status_code     <= st_d.status;
      out_o.minor_version   <= st_d.ver;
      out_o.body_length     <= st_d.len;
      out_o.date_char       <= emit ? in_i.data_byte : 8'h00;
      out_o.date_char_valid <= emit;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

// File: rtl/hrhp_checker.sv
// ----------------------------------------------------------------------------
// hrhp_checker
// Port-level checks for the HTTP response header parser.
// ----------------------------------------------------------------------------
module hrhp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [9:0]  status_code_i,
  input logic [1:0]  minor_version_i,
  input logic [31:0] body_length_i,
  input logic [7:0]  date_char_i,
  input logic        date_char_valid_i
);

  // a stalled beat keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(body_length_i) && $stable(status_code_i))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !date_char_valid_i |-> date_char_i == 8'h00)
    else $error("date_char nonzero without date_char_valid");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> minor_version_i != 2'd3)
    else $error("minor_version out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_code_i <= 10'd999)
    else $error("status_code above three digits");

endmodule

bind http_response_header_parser hrhp_checker u_hrhp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .status_code_i    (out_o.status_code),
  .minor_version_i  (out_o.minor_version),
  .body_length_i    (out_o.body_length),
  .date_char_i      (out_o.date_char),
  .date_char_valid_i(out_o.date_char_valid)
);
